// ----- src/ues_pkg.sv -----
package ues_pkg;

	// One UTF-16 code unit of the text.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_text;
	} unit_beat_t;

	// One emoji run.
	typedef struct packed {
		logic [15:0] range_start;
		logic [15:0] range_length;
		logic        last_of_run;
	} range_beat_t;

	// Properties of one code point; several may be set at once.
	typedef struct packed {
		logic base;
		logic regional;
		logic suffix;
		logic joiner;
		logic vs16;
		logic keycap_end;
		logic keycap_base;
	} cp_class_t;

	localparam int CLS_W       = $bits(cp_class_t);
	localparam int QUEUE_DEPTH = 2;
	localparam int OUT_DEPTH   = 4;

	localparam logic [15:0] HI_SURR_LO  = 16'hD800;
	localparam logic [15:0] HI_SURR_HI  = 16'hDBFF;
	localparam logic [15:0] LO_SURR_LO  = 16'hDC00;
	localparam logic [15:0] LO_SURR_HI  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [20:0] CP_JOINER   = 21'h0200D;
	localparam logic [20:0] CP_KEYCAP   = 21'h020E3;
	localparam logic [20:0] CP_VS15     = 21'h0FE0E;
	localparam logic [20:0] CP_VS16     = 21'h0FE0F;

	function automatic logic in_rng(input logic [20:0] v, input logic [20:0] lo,
			input logic [20:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic logic is_base(input logic [20:0] v);
		return in_rng(v, 21'h1F000, 21'h1FAFF) || in_rng(v, 21'h02600, 21'h027BF) ||
			in_rng(v, 21'h02194, 21'h02199) || in_rng(v, 21'h021A9, 21'h021AA) ||
			in_rng(v, 21'h0231A, 21'h0231B) || (v == 21'h02328) || (v == 21'h023CF) ||
			in_rng(v, 21'h023E9, 21'h023F3) || in_rng(v, 21'h023F8, 21'h023FA) ||
			(v == 21'h024C2) || in_rng(v, 21'h025AA, 21'h025AB) || (v == 21'h025B6) ||
			(v == 21'h025C0) || in_rng(v, 21'h025FB, 21'h025FE) ||
			in_rng(v, 21'h02934, 21'h02935) || in_rng(v, 21'h02B05, 21'h02B07) ||
			in_rng(v, 21'h02B1B, 21'h02B1C) || (v == 21'h02B50) || (v == 21'h02B55) ||
			(v == 21'h000A9) || (v == 21'h000AE) || (v == 21'h0203C) || (v == 21'h02049) ||
			(v == 21'h02122) || (v == 21'h02139) || (v == 21'h03030) || (v == 21'h0303D) ||
			(v == 21'h03297) || (v == 21'h03299);
	endfunction

	function automatic cp_class_t classify(input logic [20:0] cp);
		cp_class_t c;
		c.base        = is_base(cp);
		c.regional    = in_rng(cp, 21'h1F1E6, 21'h1F1FF);
		c.suffix      = (cp == CP_VS15) || (cp == CP_VS16) || (cp == CP_KEYCAP) ||
			in_rng(cp, 21'h1F3FB, 21'h1F3FF) || in_rng(cp, 21'hE0020, 21'hE007F);
		c.joiner      = (cp == CP_JOINER);
		c.vs16        = (cp == CP_VS16);
		c.keycap_end  = (cp == CP_KEYCAP);
		c.keycap_base = (cp == 21'h00023) || (cp == 21'h0002A) ||
			in_rng(cp, 21'h00030, 21'h00039);
		return c;
	endfunction

endpackage

// ----- src/ues_queue.sv -----
module ues_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import ues_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= bump(wp_q);
			if (do_pop) rp_q <= bump(rp_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_data;
	end

endmodule

// ----- src/ues_front.sv -----
module ues_front #(
	parameter longint unsigned MAX_TEXT_UNITS = 65536,
	localparam int POS_W   = $clog2(MAX_TEXT_UNITS),
	localparam int ENTRY_W = 2 * (1 + ues_pkg::CLS_W + POS_W) + POS_W + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_ready,
	input  ues_pkg::unit_beat_t text_item,
	output logic               entry_valid,
	input  logic               entry_ready,
	output logic [ENTRY_W-1:0] entry
);
	import ues_pkg::*;

	typedef struct packed {
		logic             vld;
		cp_class_t        cls;
		logic [POS_W-1:0] start;
	} event_t;

	typedef struct packed {
		event_t           ev0;
		event_t           ev1;
		logic             eot;
		logic [POS_W:0]   end_pos;
	} entry_t;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_UNITS - 64'd1);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      held_q;
	logic             held_vld_q;

	entry_t           ent;
	logic [POS_W-1:0] prev;
	logic             is_hi, is_lo, hold_n, accept;
	logic [15:0]      cu;
	logic [20:0]      pair_cp;

	assign cu          = text_item.code_unit;
	assign is_hi       = (cu >= HI_SURR_LO) && (cu <= HI_SURR_HI);
	assign is_lo       = (cu >= LO_SURR_LO) && (cu <= LO_SURR_HI);
	assign pair_cp     = SUPP_BASE + {1'b0, held_q[9:0], cu[9:0]};
	assign prev        = (pos_q != '0) ? pos_q - 1'b1 : '0;
	assign text_ready  = entry_ready;
	assign entry_valid = text_valid;
	assign accept      = text_valid && entry_ready;
	assign entry       = ent;

	// Greedy surrogate pairing; a unit never yields more than two code points.
	always_comb begin
		ent         = '0;
		hold_n      = 1'b0;
		ent.eot     = text_item.end_of_text;
		ent.end_pos = {1'b0, pos_q} + 1'b1;
		if (held_vld_q) begin
			if (is_lo) begin
				ent.ev0 = '{vld: 1'b1, cls: classify(pair_cp), start: prev};
			end else begin
				ent.ev0 = '{vld: 1'b1, cls: classify({5'b0, held_q}), start: prev};
				if (is_hi) begin
					hold_n = 1'b1;
					if (text_item.end_of_text) begin
						ent.ev1 = '{vld: 1'b1, cls: classify({5'b0, cu}), start: pos_q};
					end
				end else begin
					ent.ev1 = '{vld: 1'b1, cls: classify({5'b0, cu}), start: pos_q};
				end
			end
		end else if (is_hi) begin
			hold_n = 1'b1;
			if (text_item.end_of_text) begin
				ent.ev0 = '{vld: 1'b1, cls: classify({5'b0, cu}), start: pos_q};
			end
		end else begin
			ent.ev0 = '{vld: 1'b1, cls: classify({5'b0, cu}), start: pos_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
		end else if (accept) begin
			if (text_item.end_of_text) begin
				pos_q      <= '0;
				held_vld_q <= 1'b0;
			end else begin
				pos_q      <= (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
				held_vld_q <= hold_n;
				if (hold_n) held_q <= cu;
			end
		end
	end

endmodule

// ----- src/ues_back.sv -----
module ues_back #(
	parameter int POS_W = 16,
	localparam int ENTRY_W = 2 * (1 + ues_pkg::CLS_W + POS_W) + POS_W + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                entry_valid,
	output logic                entry_ready,
	input  logic [ENTRY_W-1:0]  entry,
	output logic                range_valid,
	input  logic                range_ready,
	output ues_pkg::range_beat_t range_item
);
	import ues_pkg::*;

	typedef struct packed {
		logic             vld;
		cp_class_t        cls;
		logic [POS_W-1:0] start;
	} event_t;

	typedef struct packed {
		event_t           ev0;
		event_t           ev1;
		logic             eot;
		logic [POS_W:0]   end_pos;
	} entry_t;

	typedef struct packed {
		logic             run_open;
		logic [POS_W-1:0] run_start;
		logic             regional_pair_open;
		logic             absorb_after_joiner;
		logic             keycap_pending;
		logic [POS_W-1:0] keycap_start;
	} run_st_t;

	localparam int CW    = (POS_W + 1 > 16) ? POS_W + 1 : 16;
	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	run_st_t          st_q;
	range_beat_t      rng_q [OUT_DEPTH];
	logic [OPTR_W-1:0] wp_q, rp_q;
	logic [OCNT_W-1:0] cnt_q;

	entry_t           ent;
	run_st_t          st1, st2, st_n;
	logic [2:0]       cand_v;
	range_beat_t      cand [3];
	logic [POS_W-1:0] es0, es1;
	range_beat_t      r0, r1;
	logic [1:0]       n;
	logic             pop, out_pop;

	function automatic void judge(input run_st_t s, input event_t ev, output run_st_t ns,
			output logic emit_v, output logic [POS_W-1:0] emit_s);
		logic done;
		ns     = s;
		emit_v = 1'b0;
		emit_s = s.run_start;
		done   = !ev.vld;
		if (!done && ns.run_open) begin
			if (ns.absorb_after_joiner) begin
				ns.absorb_after_joiner = 1'b0;
				done = 1'b1;
			end else if (ev.cls.suffix || (ns.regional_pair_open && ev.cls.regional)) begin
				ns.regional_pair_open = 1'b0;
				done = 1'b1;
			end else if (ev.cls.joiner) begin
				ns.absorb_after_joiner = 1'b1;
				done = 1'b1;
			end else begin
				emit_v = 1'b1;
				ns.run_open = 1'b0;
				ns.regional_pair_open = 1'b0;
			end
		end
		if (!done && ns.keycap_pending) begin
			if (ev.cls.vs16) begin
				done = 1'b1;
			end else begin
				ns.keycap_pending = 1'b0;
				if (ev.cls.keycap_end) begin
					ns.run_open = 1'b1;
					ns.run_start = ns.keycap_start;
					ns.regional_pair_open = 1'b0;
					ns.absorb_after_joiner = 1'b0;
					done = 1'b1;
				end
			end
		end
		if (!done) begin
			if (ev.cls.base) begin
				ns.run_open = 1'b1;
				ns.run_start = ev.start;
				ns.regional_pair_open = ev.cls.regional;
				ns.absorb_after_joiner = 1'b0;
			end else if (ev.cls.keycap_base) begin
				ns.keycap_pending = 1'b1;
				ns.keycap_start = ev.start;
			end
		end
	endfunction

	function automatic range_beat_t mk_range(input logic [POS_W-1:0] s, input logic [POS_W:0] e);
		logic [POS_W:0] len;
		logic [CW-1:0]  len_w, s_w;
		range_beat_t    r;
		len = (e > {1'b0, s}) ? e - {1'b0, s} : (POS_W + 1)'(1);
		len_w = CW'(len);
		s_w   = CW'(s);
		r.range_length = (len_w > CW'(16'hFFFF)) ? 16'hFFFF : len_w[15:0];
		r.range_start  = (s_w > CW'(16'hFFFF)) ? 16'hFFFF : s_w[15:0];
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	assign ent = entry;

	// Room for two results is kept free so a beat never has to wait halfway.
	assign entry_ready = (cnt_q <= OCNT_W'(OUT_DEPTH - 2));
	assign pop         = entry_valid && entry_ready;
	assign range_valid = (cnt_q != '0);
	assign range_item  = rng_q[rp_q];
	assign out_pop     = range_valid && range_ready;

	always_comb begin
		judge(st_q, ent.ev0, st1, cand_v[0], es0);
		judge(st1, ent.ev1, st2, cand_v[1], es1);
		cand[0]   = mk_range(es0, {1'b0, ent.ev0.start});
		cand[1]   = mk_range(es1, {1'b0, ent.ev1.start});
		cand_v[2] = ent.eot && st2.run_open;
		cand[2]   = mk_range(st2.run_start, ent.end_pos);
		st_n      = ent.eot ? '0 : st2;
	end

	always_comb begin
		r0 = cand[0];
		r1 = cand[1];
		n  = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (cand_v[i]) begin
				if (n == 2'd0) r0 = cand[i];
				else if (n == 2'd1) r1 = cand[i];
				if (n != 2'd2) n = n + 2'd1;
			end
		end
		r0.last_of_run = (n == 2'd1);
		r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				st_q <= st_n;
				wp_q <= wp_q + OPTR_W'(n);
			end
			if (out_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + OCNT_W'(pop ? n : 2'd0) - OCNT_W'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (n != 2'd0)) rng_q[wp_q] <= r0;
		if (pop && (n == 2'd2)) rng_q[wp_q + 1'b1] <= r1;
	end

endmodule

// ----- src/utf16_emoji_run_segmenter_core.sv -----
// UTF-16 emoji run segmenter.
// The text channel (text_valid/text_ready/text_item) takes one code unit per
// beat; end_of_text on a beat closes the text and sets the offset back to zero.
// The range channel (range_valid/range_ready/range_item) gives the start and
// length of each emoji run; last_of_run marks the final range a text beat
// caused. A beat causes zero, one or two ranges.
// The front stage pairs surrogates, counts offsets and classifies code points
// in the accept cycle; a two-entry queue hands them to the back stage, whose
// run tracker resolves both code points of a beat together and writes the
// ranges into a four-entry output buffer.
// Throughput is one text beat per cycle while the receiver keeps up and the
// beats cause no more than one range each on average.
// A range can be taken only after the beat completing it has been registered
// in the queue and then in the output buffer.
// A receiver stall fills the output buffer, then the queue, and then
// text_ready drops; nothing is lost. Reset empties both buffers and clears the
// offset counter and all run state; no clearing pass follows.
module utf16_emoji_run_segmenter_core #(
	parameter longint unsigned MAX_TEXT_UNITS = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_ready,
	input  ues_pkg::unit_beat_t  text_item,
	output logic                 range_valid,
	input  logic                 range_ready,
	output ues_pkg::range_beat_t range_item
);
	import ues_pkg::*;

	localparam int POS_W   = $clog2(MAX_TEXT_UNITS);
	localparam int ENTRY_W = 2 * (1 + CLS_W + POS_W) + POS_W + 2;

	logic               f_valid, f_ready, b_valid, b_ready;
	logic [ENTRY_W-1:0] f_entry, b_entry;

	ues_front #(
		.MAX_TEXT_UNITS(MAX_TEXT_UNITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_item  (text_item),
		.entry_valid(f_valid),
		.entry_ready(f_ready),
		.entry      (f_entry)
	);

	ues_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_entry),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_entry)
	);

	ues_back #(
		.POS_W(POS_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_valid(b_valid),
		.entry_ready(b_ready),
		.entry      (b_entry),
		.range_valid(range_valid),
		.range_ready(range_ready),
		.range_item (range_item)
	);

endmodule
